FILE: hdl/bbs_pkg.sv
`timescale 1ns / 1ps

package bbs_pkg;

    localparam int DATA_W      = 32;
    localparam int STORE_DEPTH = 64;
    localparam int DEF_SIZE    = 64;

    localparam logic signed [DATA_W-1:0] PAD_WORD = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     overflow;
    } t_out;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD,
        ST_SORT,
        ST_GAP,
        ST_OUT
    } t_state;

    // network span: next power of two at or above the block size, at least 2 and at most STORE_DEPTH
    function automatic int span_of(input int size);
        int p;
        p = 2;
        while (p < size && p < STORE_DEPTH) p = p * 2;
        return p;
    endfunction

endpackage

FILE: hdl/bbs_ram.sv
`timescale 1ns / 1ps

module bbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/bitonic_block_sorter_core.sv
// loading: one word per cycle, the closing word starts the sort
// padding: each unused slot of the span (span minus loaded count) is written with the pad word in turn
// sorting: log2(span)*(log2(span)+1)/2 passes of span/2 pairs and a gap state, one pair per cycle
//   through two one-read one-write ram banks
// emitting: bounded by the registered ram read; a read waits for the previous word and a free output
// reset (synchronous, active low) clears control and counts, the word ram is not cleared
`timescale 1ns / 1ps

module bitonic_block_sorter_core import bbs_pkg::*; #(
    parameter int SIZE = DEF_SIZE
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int SPAN   = span_of(SIZE);
    localparam int IW     = $clog2(SPAN);
    localparam int BANK_D = SPAN / 2;
    localparam int BAW    = (IW > 1) ? IW - 1 : 1;
    localparam int CW     = $clog2(SIZE + 1);
    localparam int LW     = $clog2(IW + 1);

    t_state r_state, n_state;

    logic [CW-1:0]  r_cnt;
    logic           r_drop;
    logic [IW-1:0]  r_idx;
    logic [BAW-1:0] r_q;
    logic [LW-1:0]  r_kl;
    logic [LW-1:0]  r_jl;
    logic           r_done;

    logic           r_wb_vld;
    logic           r_wb_swap;
    logic           r_wb_up;
    logic [BAW-1:0] r_wb_a0;
    logic [BAW-1:0] r_wb_a1;

    logic [CW-1:0]  r_oidx;
    logic           r_rd_pend;
    logic           r_rd_bank;
    logic           r_rd_last;
    logic           r_issued_all;
    logic           r_out_vld;
    t_out           r_out;

    logic                     s_we0, s_we1;
    logic [BAW-1:0]           s_wa0, s_wa1, s_ra0, s_ra1;
    logic signed [DATA_W-1:0] s_wd0, s_wd1;
    logic signed [DATA_W-1:0] s_rd0, s_rd1;

    logic           s_in_xfer, s_out_xfer, s_room, s_out_rd, s_last_pair;
    logic [CW-1:0]  s_cnt_after;
    logic [IW-1:0]  s_ld_idx, s_rd_idx;
    logic [IW-1:0]  s_qe, s_low, s_i, s_l, s_ksh;
    logic           s_up, s_swap;
    logic [BAW-1:0] s_a_i, s_a_l;

    logic signed [DATA_W-1:0] s_vi, s_vl, s_ni, s_nl;
    logic                     s_xchg;

    assign s_in_xfer   = i_in_valid && o_in_ready;
    assign s_out_xfer  = r_out_vld && i_out_ready;
    assign s_room      = (r_cnt < CW'(SIZE));
    assign s_cnt_after = r_cnt + CW'(s_room);
    assign s_ld_idx    = r_cnt[IW-1:0];
    assign s_rd_idx    = r_oidx[IW-1:0];
    assign s_last_pair = (r_q == BAW'(BANK_D - 1));

    // pair of the current pass: i has bit j clear, l = i | j
    always_comb begin
        s_qe  = IW'(r_q);
        s_low = (IW'(1) << r_jl) - IW'(1);
        s_i   = ((s_qe & ~s_low) << 1) | (s_qe & s_low);
        s_l   = s_i | (IW'(1) << r_jl);
        s_ksh = s_i >> r_kl;
        s_up  = ~s_ksh[0];
        s_swap = ^s_i;
        s_a_i = BAW'(s_i >> 1);
        s_a_l = BAW'(s_l >> 1);
    end

    // compare-exchange on the returned pair
    always_comb begin
        s_vi   = r_wb_swap ? s_rd1 : s_rd0;
        s_vl   = r_wb_swap ? s_rd0 : s_rd1;
        s_xchg = r_wb_up ? (s_vi > s_vl) : (s_vl > s_vi);
        s_ni   = s_xchg ? s_vl : s_vi;
        s_nl   = s_xchg ? s_vi : s_vl;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (s_in_xfer && i_in_data.last) begin
                    n_state = (int'(s_cnt_after) == SPAN) ? ST_SORT : ST_PAD;
                end
            end
            ST_PAD: begin
                if (r_idx == IW'(SPAN - 1)) n_state = ST_SORT;
            end
            ST_SORT: begin
                if (s_last_pair) n_state = ST_GAP;
            end
            ST_GAP: begin
                n_state = r_done ? ST_OUT : ST_SORT;
            end
            ST_OUT: begin
                if (s_out_xfer && r_out.final_res) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // ram control and handshake outputs
    always_comb begin
        s_we0      = 1'b0;
        s_we1      = 1'b0;
        s_wa0      = '0;
        s_wa1      = '0;
        s_wd0      = '0;
        s_wd1      = '0;
        s_ra0      = '0;
        s_ra1      = '0;
        o_in_ready = 1'b0;
        s_out_rd   = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                s_wa0 = BAW'(s_ld_idx >> 1);
                s_wa1 = BAW'(s_ld_idx >> 1);
                s_wd0 = i_in_data.value;
                s_wd1 = i_in_data.value;
                s_we0 = s_in_xfer && s_room && !(^s_ld_idx);
                s_we1 = s_in_xfer && s_room && (^s_ld_idx);
            end
            ST_PAD: begin
                s_wa0 = BAW'(r_idx >> 1);
                s_wa1 = BAW'(r_idx >> 1);
                s_wd0 = PAD_WORD;
                s_wd1 = PAD_WORD;
                s_we0 = !(^r_idx);
                s_we1 = ^r_idx;
            end
            ST_SORT: begin
                s_ra0 = s_swap ? s_a_l : s_a_i;
                s_ra1 = s_swap ? s_a_i : s_a_l;
            end
            ST_GAP: begin
            end
            ST_OUT: begin
                s_ra0    = BAW'(s_rd_idx >> 1);
                s_ra1    = BAW'(s_rd_idx >> 1);
                s_out_rd = !r_rd_pend && !r_issued_all && (!r_out_vld || i_out_ready);
            end
            default: begin
            end
        endcase
        if (r_wb_vld) begin
            s_we0 = 1'b1;
            s_we1 = 1'b1;
            s_wa0 = r_wb_a0;
            s_wa1 = r_wb_a1;
            s_wd0 = r_wb_swap ? s_nl : s_ni;
            s_wd1 = r_wb_swap ? s_ni : s_nl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_cnt        <= '0;
            r_drop       <= 1'b0;
            r_q          <= '0;
            r_kl         <= LW'(1);
            r_jl         <= '0;
            r_done       <= 1'b0;
            r_wb_vld     <= 1'b0;
            r_oidx       <= '0;
            r_rd_pend    <= 1'b0;
            r_issued_all <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wb_vld  <= (r_state == ST_SORT);
            r_rd_pend <= s_out_rd;

            if (s_in_xfer) begin
                if (s_room) r_cnt <= s_cnt_after;
                else        r_drop <= 1'b1;
                if (i_in_data.last) begin
                    r_q    <= '0;
                    r_kl   <= LW'(1);
                    r_jl   <= '0;
                    r_done <= 1'b0;
                end
            end

            if (r_state == ST_SORT) begin
                if (s_last_pair) begin
                    r_q <= '0;
                    if (r_jl == '0) begin
                        if (int'(r_kl) == IW) begin
                            r_done <= 1'b1;
                        end else begin
                            r_kl <= r_kl + LW'(1);
                            r_jl <= r_kl;
                        end
                    end else begin
                        r_jl <= r_jl - LW'(1);
                    end
                end else begin
                    r_q <= r_q + BAW'(1);
                end
            end

            if (r_state == ST_GAP && r_done) begin
                r_oidx       <= '0;
                r_issued_all <= 1'b0;
            end

            if (s_out_rd) begin
                r_oidx <= r_oidx + CW'(1);
                if (r_oidx == r_cnt - CW'(1)) r_issued_all <= 1'b1;
            end

            if (r_rd_pend)       r_out_vld <= 1'b1;
            else if (s_out_xfer) r_out_vld <= 1'b0;

            // block fully delivered
            if (s_out_xfer && r_out.final_res) begin
                r_cnt  <= '0;
                r_drop <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_in_xfer && i_in_data.last) begin
            r_idx <= s_cnt_after[IW-1:0];
        end else if (r_state == ST_PAD) begin
            r_idx <= r_idx + IW'(1);
        end
        if (r_state == ST_SORT) begin
            r_wb_swap <= s_swap;
            r_wb_up   <= s_up;
            r_wb_a0   <= s_swap ? s_a_l : s_a_i;
            r_wb_a1   <= s_swap ? s_a_i : s_a_l;
        end
        if (s_out_rd) begin
            r_rd_bank <= ^s_rd_idx;
            r_rd_last <= (r_oidx == r_cnt - CW'(1));
        end
        if (r_rd_pend) begin
            r_out.sorted_value <= r_rd_bank ? s_rd1 : s_rd0;
            r_out.final_res    <= r_rd_last;
            r_out.overflow     <= r_drop;
        end
    end

    bbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BANK_D)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (s_we0),
        .i_waddr (s_wa0),
        .i_wdata (s_wd0),
        .i_raddr (s_ra0),
        .o_rdata (s_rd0)
    );

    bbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BANK_D)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (s_we1),
        .i_waddr (s_wa1),
        .i_wdata (s_wd1),
        .i_raddr (s_ra1),
        .o_rdata (s_rd1)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: hdl/bbs_chk.sv
`timescale 1ns / 1ps

module bbs_chk import bbs_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no input transfer while a block is being emitted
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while results pending");

    // closing word stops intake
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last |=> !o_in_ready)
        else $error("input still ready after closing word");

    // nothing follows the final result of a block
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.final_res |=> !o_out_valid)
        else $error("result after final transfer");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("bad state after reset");

endmodule

bind bitonic_block_sorter_core bbs_chk u_bbs_chk (.*);

FILE: tb/sv/bbs_sort_checker.sv
`timescale 1ns / 1ps

module bbs_sort_checker import bbs_pkg::*; #(
    parameter int SIZE = DEF_SIZE
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int HOLD_LIMIT = (SIZE > STORE_DEPTH) ? STORE_DEPTH : SIZE;

    logic signed [DATA_W-1:0] block_words [0:STORE_DEPTH-1];
    int                       block_len;
    logic                     block_dropped;
    t_out                     sorted_fifo [$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        block_len     = 0;
        block_dropped = 1'b0;
    end

    // keep the held words in ascending order, emit them when the block closes
    task automatic take_word(input t_in item);
        logic signed [DATA_W-1:0] v;
        int                       pos;
        int                       i;
        t_out                     res;
        begin
            v = item.value;
            if (block_len < HOLD_LIMIT) begin
                pos = block_len;
                while (pos > 0 && block_words[pos-1] > v) begin
                    block_words[pos] = block_words[pos-1];
                    pos--;
                end
                block_words[pos] = v;
                block_len++;
            end else begin
                block_dropped = 1'b1;
            end
            if (item.last) begin
                for (i = 0; i < block_len; i++) begin
                    res.sorted_value = block_words[i];
                    res.final_res    = (i == block_len - 1);
                    res.overflow     = block_dropped;
                    sorted_fifo.push_back(res);
                end
                block_len     = 0;
                block_dropped = 1'b0;
            end
        end
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        begin
            if (sorted_fifo.size() == 0) begin
                $error("unexpected result: sorted_value %0d final_res %0b overflow %0b",
                       got.sorted_value, got.final_res, got.overflow);
                o_fail_count++;
            end else begin
                want = sorted_fifo.pop_front();
                if (got.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, got.sorted_value);
                    o_fail_count++;
                end
                if (got.final_res !== want.final_res) begin
                    $error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
                    o_fail_count++;
                end
                if (got.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                    o_fail_count++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            block_len     = 0;
            block_dropped = 1'b0;
            sorted_fifo.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) take_word(i_in_data);
        end
        o_pending = sorted_fifo.size();
    end

endmodule

FILE: tb/sv/tb_bitonic_block_sorter_core.sv
`timescale 1ns / 1ps

module tb_bitonic_block_sorter_core import bbs_pkg::*;;

    localparam int SORT_SIZE   = DEF_SIZE;
    localparam int STALL_LIMIT = 5000;
    localparam int TOTAL_WORDS = 350;

    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    int fail_count;
    int pending;
    int send_idle;
    int recv_stall;
    int words_sent;
    int quiet_cycles;

    bitonic_block_sorter_core #(
        .SIZE(SORT_SIZE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    bbs_sort_checker #(
        .SIZE(SORT_SIZE)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_word();
        int k;
        int t;
        k = $urandom_range(9);
        t = $urandom_range(8);
        case (k)
            0: return WORD_MIN;
            1: return WORD_MAX;
            2, 3: return t - 4;
            default: return $urandom;
        endcase
    endfunction

    // one transfer on the input channel, entered and left at a falling edge
    task automatic send_word(input logic signed [DATA_W-1:0] v, input logic l);
        begin
            while ($urandom_range(99) < send_idle) begin
                in_valid <= 1'b0;
                @(negedge i_clk);
            end
            in_valid      <= 1'b1;
            in_data.value <= v;
            in_data.last  <= l;
            @(posedge i_clk);
            while (!in_ready) @(posedge i_clk);
            words_sent++;
            @(negedge i_clk);
        end
    endtask

    task automatic send_block(input int len);
        int i;
        begin
            for (i = 0; i < len; i++) send_word(rand_word(), i == len - 1);
        end
    endtask

    initial begin
        int phase;
        int k;
        int len;
        int target;

        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        send_idle    = 0;
        recv_stall   = 0;
        words_sent   = 0;
        quiet_cycles = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-word blocks at both extremes
        send_word(WORD_MIN, 1'b1);
        send_word(WORD_MAX, 1'b1);
        // duplicates and words equal to the pad value, then short mixed-sign blocks
        send_word(WORD_MAX, 1'b0);
        send_word(WORD_MIN, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b0);
        send_word(WORD_MAX, 1'b0);
        send_word(1, 1'b1);
        send_word(5, 1'b0);
        send_word(-5, 1'b1);
        send_word(-3, 1'b0);
        send_word(0, 1'b0);
        send_word(3, 1'b1);
        send_word(32'sh5555_5555, 1'b0);
        send_word(32'shaaaa_aaaa, 1'b1);

        // full store, then full store with the closing word dropped
        send_block(SORT_SIZE);
        send_block(SORT_SIZE + 1);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 63; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 63; end
                default: begin send_idle = 29; recv_stall = 29; end
            endcase
            target = words_sent + (TOTAL_WORDS - words_sent) / (4 - phase);
            while (words_sent < target) begin
                k = $urandom_range(11);
                if (k < 9) len = $urandom_range(12, 1);
                else if (k == 9) len = $urandom_range(SORT_SIZE - 1, 13);
                else if (k == 10) len = SORT_SIZE;
                else len = SORT_SIZE + $urandom_range(4, 1);
                send_block(len);
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/bbs_pkg.sv
hdl/bbs_ram.sv
hdl/bitonic_block_sorter_core.sv
hdl/bbs_chk.sv
tb/sv/bbs_sort_checker.sv
tb/sv/tb_bitonic_block_sorter_core.sv
